FILE: rtl/lrsp_pkg.sv
package lrsp_pkg;

    localparam int STATES_DEF      = 128;
    localparam int SYMBOLS_DEF     = 128;
    localparam int RULES_DEF       = 128;
    localparam int RULE_LEN_DEF    = 10;
    localparam int STACK_DEPTH_DEF = 64;
    localparam int MAX_REDUCES_DEF = 63;

    localparam logic [1:0] F_LOAD_ACTION = 2'd0;
    localparam logic [1:0] F_LOAD_RULE   = 2'd1;
    localparam logic [1:0] F_LOAD_MAP    = 2'd2;
    localparam logic [1:0] F_TOKEN       = 2'd3;

    localparam logic [2:0] K_ERROR  = 3'd0;
    localparam logic [2:0] K_SHIFT  = 3'd1;
    localparam logic [2:0] K_REDUCE = 3'd2;
    localparam logic [2:0] K_ACCEPT = 3'd3;
    localparam logic [2:0] K_GOTO   = 3'd4;

    localparam logic [1:0] R_SHIFT  = 2'd0;
    localparam logic [1:0] R_REDUCE = 2'd1;
    localparam logic [1:0] R_ACCEPT = 2'd2;
    localparam logic [1:0] R_ERROR  = 2'd3;

    localparam logic [2:0] C_NONE    = 3'd0;
    localparam logic [2:0] C_TABLE   = 3'd1;
    localparam logic [2:0] C_STACK   = 3'd2;
    localparam logic [2:0] C_LIMIT   = 3'd3;
    localparam logic [2:0] C_UNKNOWN = 3'd4;

    localparam logic CFG_SYMBOL_COUNT = 1'b0;
    localparam logic CFG_END_SYMBOL   = 1'b1;

endpackage

FILE: rtl/lrsp_ram.sv
module lrsp_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] wa,
    input  logic [W-1:0]  wd,
    input  logic          re,
    input  logic [AW-1:0] ra,
    output logic [W-1:0]  rd
);

    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (re)
        begin
            rd_reg <= mem[ra];
        end
    end

    assign rd = rd_reg;

endmodule

FILE: rtl/lr_shift_reduce_parser.sv
// Sequence: a load is written as it is taken. A token is taken and the symbol map searched entry
// by entry; a reduction runs action read, rule read, stack read, goto read and push, and the final
// action is read and decoded; an end-of-input item skips the search, and an unknown token ends in
// the search state after its last compare. Each result step waits while out_valid and out_stall hold.
// Throughput: one item at a time; the next is taken when the engine is back in idle.
// Reset: after rst_n rises the action table is cleared to error, one entry a cycle, with input
// stalled; configuration writes are taken throughout.
module lr_shift_reduce_parser #(
    parameter int STATES      = lrsp_pkg::STATES_DEF,
    parameter int SYMBOLS     = lrsp_pkg::SYMBOLS_DEF,
    parameter int RULES       = lrsp_pkg::RULES_DEF,
    parameter int RULE_LEN    = lrsp_pkg::RULE_LEN_DEF,
    parameter int STACK_DEPTH = lrsp_pkg::STACK_DEPTH_DEF,
    parameter int MAX_REDUCES = lrsp_pkg::MAX_REDUCES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] func,
    input  logic [6:0] row,
    input  logic [6:0] column,
    input  logic [2:0] act_kind,
    input  logic [6:0] act_value,
    input  logic [3:0] body_length,
    input  logic [7:0] token_id,
    input  logic       end_of_input,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] kind,
    output logic [6:0] code,
    output logic [6:0] top_state,
    output logic [2:0] error_cause,
    output logic       last
);

    localparam int AA_DEPTH = STATES * SYMBOLS;
    localparam int AA_W     = $clog2(AA_DEPTH);
    localparam int RU_W     = (RULES > 1) ? $clog2(RULES) : 1;
    localparam int SY_W     = $clog2(SYMBOLS);
    localparam int SP_W     = $clog2(STACK_DEPTH);

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_SRCH  = 4'd2;
    localparam logic [3:0] S_SCMP  = 4'd3;
    localparam logic [3:0] S_ACT   = 4'd4;
    localparam logic [3:0] S_ADEC  = 4'd5;
    localparam logic [3:0] S_RULE  = 4'd6;
    localparam logic [3:0] S_BELOW = 4'd7;
    localparam logic [3:0] S_GOTO  = 4'd8;

    logic [3:0]      state_reg, state_next;
    logic [AA_W-1:0] clr_reg, clr_next;
    logic [7:0]      symcnt_reg, symcnt_next;
    logic [6:0]      endsym_reg, endsym_next;
    logic [7:0]      tok_reg, tok_next;
    logic [7:0]      idx_reg, idx_next;
    logic [7:0]      sym_reg, sym_next;
    logic [6:0]      top_reg, top_next;
    logic [SP_W-1:0] sp_reg, sp_next;
    logic [5:0]      red_reg, red_next;
    logic [6:0]      rule_reg, rule_next;
    logic [6:0]      head_reg, head_next;
    logic            ok_reg, ok_next;

    logic            ov_reg, ov_next;
    logic [1:0]      kind_reg, kind_next;
    logic [6:0]      code_reg, code_next;
    logic [6:0]      top_o_reg, top_o_next;
    logic [2:0]      cause_reg, cause_next;
    logic            last_reg, last_next;

    logic            in_acc, adv;
    logic            act_we, act_re;
    logic [AA_W-1:0] act_wa, act_ra;
    logic [9:0]      act_wd, act_rd;
    logic            rule_we, rule_re;
    logic [RU_W-1:0] rule_wa, rule_ra;
    logic [10:0]     rule_wd, rule_rd;
    logic [3:0]      rule_len_sat;
    logic            map_we, map_re;
    logic [SY_W-1:0] map_wa, map_ra;
    logic [7:0]      map_rd;
    logic            stk_we, stk_re;
    logic [SP_W-1:0] stk_wa, stk_ra;
    logic [6:0]      stk_wd, stk_rd;

    logic            e_valid, fin_err;
    logic [1:0]      e_kind;
    logic [6:0]      e_code, e_top;
    logic [2:0]      e_cause, fin_cause;
    logic            e_last;
    logic [2:0]      a_kind;
    logic [6:0]      a_val, below;
    logic [3:0]      r_len;

    assign in_stall = (state_reg != S_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign adv      = !ov_reg || !out_stall;

    assign a_kind = ok_reg ? act_rd[9:7] : lrsp_pkg::K_ERROR;
    assign a_val  = act_rd[6:0];
    assign r_len  = rule_rd[10:7];
    assign below  = (sp_reg == '0) ? 7'd0 : stk_rd;

    assign rule_len_sat = (32'(body_length) > RULE_LEN - 2) ? 4'(RULE_LEN - 2) : body_length;

    always_comb
    begin
        symcnt_next = symcnt_reg;
        endsym_next = endsym_reg;
        if (cfg_we && cfg_index == lrsp_pkg::CFG_SYMBOL_COUNT)
        begin
            symcnt_next = cfg_data;
        end
        if (cfg_we && cfg_index == lrsp_pkg::CFG_END_SYMBOL)
        begin
            endsym_next = cfg_data[6:0];
        end
    end

    always_comb
    begin
        map_we  = in_acc && func == lrsp_pkg::F_LOAD_MAP && 32'(row) < SYMBOLS;
        map_wa  = SY_W'(row);
        rule_we = in_acc && func == lrsp_pkg::F_LOAD_RULE && 32'(row) < RULES;
        rule_wa = RU_W'(row);
        rule_wd = {rule_len_sat, act_value};
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        tok_next   = tok_reg;
        idx_next   = idx_reg;
        sym_next   = sym_reg;
        top_next   = top_reg;
        sp_next    = sp_reg;
        red_next   = red_reg;
        rule_next  = rule_reg;
        head_next  = head_reg;
        ok_next    = ok_reg;
        act_we     = 1'b0;
        act_wa     = AA_W'(row) * AA_W'(SYMBOLS) + AA_W'(column);
        act_wd     = {act_kind, act_value};
        act_re     = 1'b0;
        act_ra     = '0;
        rule_re    = 1'b0;
        rule_ra    = RU_W'(a_val);
        map_re     = 1'b0;
        map_ra     = SY_W'(idx_reg);
        stk_we     = 1'b0;
        stk_wa     = sp_reg + SP_W'(1);
        stk_wd     = a_val;
        stk_re     = 1'b0;
        stk_ra     = sp_reg - SP_W'(r_len);
        e_valid    = 1'b0;
        e_kind     = lrsp_pkg::R_SHIFT;
        e_code     = 7'd0;
        e_top      = 7'd0;
        e_cause    = lrsp_pkg::C_NONE;
        e_last     = 1'b0;
        fin_err    = 1'b0;
        fin_cause  = lrsp_pkg::C_NONE;

        case (state_reg)
            S_CLR:
            begin
                act_we   = 1'b1;
                act_wa   = clr_reg;
                act_wd   = '0;
                clr_next = clr_reg + AA_W'(1);
                if (32'(clr_reg) == AA_DEPTH - 1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                act_we = in_acc && func == lrsp_pkg::F_LOAD_ACTION
                         && 32'(row) < STATES && 32'(column) < SYMBOLS;
                if (in_acc && func == lrsp_pkg::F_TOKEN)
                begin
                    tok_next = token_id;
                    red_next = '0;
                    idx_next = '0;
                    if (end_of_input)
                    begin
                        sym_next   = {1'b0, endsym_reg};
                        state_next = S_ACT;
                    end
                    else
                    begin
                        state_next = S_SRCH;
                    end
                end
            end
            S_SRCH:
            begin
                if (adv)
                begin
                    if (idx_reg < symcnt_reg && 32'(idx_reg) < SYMBOLS)
                    begin
                        map_re     = 1'b1;
                        state_next = S_SCMP;
                    end
                    else
                    begin
                        fin_err   = 1'b1;
                        fin_cause = lrsp_pkg::C_UNKNOWN;
                    end
                end
            end
            S_SCMP:
            begin
                if (map_rd == tok_reg)
                begin
                    sym_next   = idx_reg;
                    state_next = S_ACT;
                end
                else
                begin
                    idx_next   = idx_reg + 8'd1;
                    state_next = S_SRCH;
                end
            end
            S_ACT:
            begin
                if (adv)
                begin
                    act_re     = 1'b1;
                    act_ra     = AA_W'(top_reg) * AA_W'(SYMBOLS) + AA_W'(sym_reg);
                    ok_next    = 32'(top_reg) < STATES && 32'(sym_reg) < SYMBOLS;
                    state_next = S_ADEC;
                end
            end
            S_ADEC:
            begin
                if (adv)
                begin
                    case (a_kind)
                        lrsp_pkg::K_SHIFT:
                        begin
                            if (32'(sp_reg) + 1 >= STACK_DEPTH)
                            begin
                                fin_err   = 1'b1;
                                fin_cause = lrsp_pkg::C_STACK;
                            end
                            else
                            begin
                                stk_we     = 1'b1;
                                sp_next    = sp_reg + SP_W'(1);
                                top_next   = a_val;
                                e_valid    = 1'b1;
                                e_kind     = lrsp_pkg::R_SHIFT;
                                e_code     = a_val;
                                e_top      = a_val;
                                e_last     = 1'b1;
                                state_next = S_IDLE;
                            end
                        end
                        lrsp_pkg::K_ACCEPT:
                        begin
                            sp_next    = '0;
                            top_next   = 7'd0;
                            e_valid    = 1'b1;
                            e_kind     = lrsp_pkg::R_ACCEPT;
                            e_last     = 1'b1;
                            state_next = S_IDLE;
                        end
                        lrsp_pkg::K_REDUCE:
                        begin
                            if (32'(red_reg) >= MAX_REDUCES)
                            begin
                                fin_err   = 1'b1;
                                fin_cause = lrsp_pkg::C_LIMIT;
                            end
                            else if (32'(a_val) >= RULES)
                            begin
                                fin_err   = 1'b1;
                                fin_cause = lrsp_pkg::C_TABLE;
                            end
                            else
                            begin
                                rule_re    = 1'b1;
                                rule_next  = a_val;
                                state_next = S_RULE;
                            end
                        end
                        default:
                        begin
                            fin_err   = 1'b1;
                            fin_cause = lrsp_pkg::C_TABLE;
                        end
                    endcase
                end
            end
            S_RULE:
            begin
                if (adv)
                begin
                    if (32'(r_len) > 32'(sp_reg))
                    begin
                        fin_err   = 1'b1;
                        fin_cause = lrsp_pkg::C_STACK;
                    end
                    else
                    begin
                        stk_re     = 1'b1;
                        sp_next    = sp_reg - SP_W'(r_len);
                        head_next  = rule_rd[6:0];
                        state_next = S_BELOW;
                    end
                end
            end
            S_BELOW:
            begin
                if (adv)
                begin
                    act_re     = 1'b1;
                    act_ra     = AA_W'(below) * AA_W'(SYMBOLS) + AA_W'(head_reg);
                    ok_next    = 32'(below) < STATES && 32'(head_reg) < SYMBOLS;
                    state_next = S_GOTO;
                end
            end
            S_GOTO:
            begin
                if (adv)
                begin
                    if (a_kind != lrsp_pkg::K_GOTO)
                    begin
                        fin_err   = 1'b1;
                        fin_cause = lrsp_pkg::C_TABLE;
                    end
                    else if (32'(sp_reg) + 1 >= STACK_DEPTH)
                    begin
                        fin_err   = 1'b1;
                        fin_cause = lrsp_pkg::C_STACK;
                    end
                    else
                    begin
                        stk_we     = 1'b1;
                        sp_next    = sp_reg + SP_W'(1);
                        top_next   = a_val;
                        red_next   = red_reg + 6'd1;
                        e_valid    = 1'b1;
                        e_kind     = lrsp_pkg::R_REDUCE;
                        e_code     = rule_reg;
                        e_top      = a_val;
                        e_last     = 1'b0;
                        state_next = S_ACT;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (fin_err)
        begin
            sp_next    = '0;
            top_next   = 7'd0;
            e_valid    = 1'b1;
            e_kind     = lrsp_pkg::R_ERROR;
            e_code     = 7'd0;
            e_top      = 7'd0;
            e_cause    = fin_cause;
            e_last     = 1'b1;
            state_next = S_IDLE;
        end
    end

    always_comb
    begin
        ov_next    = e_valid || (ov_reg && out_stall);
        kind_next  = e_valid ? e_kind  : kind_reg;
        code_next  = e_valid ? e_code  : code_reg;
        top_o_next = e_valid ? e_top   : top_o_reg;
        cause_next = e_valid ? e_cause : cause_reg;
        last_next  = e_valid ? e_last  : last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLR;
            clr_reg    <= '0;
            symcnt_reg <= 8'd128;
            endsym_reg <= 7'd0;
            tok_reg    <= '0;
            idx_reg    <= '0;
            sym_reg    <= '0;
            top_reg    <= '0;
            sp_reg     <= '0;
            red_reg    <= '0;
            rule_reg   <= '0;
            head_reg   <= '0;
            ok_reg     <= 1'b0;
            ov_reg     <= 1'b0;
            kind_reg   <= '0;
            code_reg   <= '0;
            top_o_reg  <= '0;
            cause_reg  <= '0;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            symcnt_reg <= symcnt_next;
            endsym_reg <= endsym_next;
            tok_reg    <= tok_next;
            idx_reg    <= idx_next;
            sym_reg    <= sym_next;
            top_reg    <= top_next;
            sp_reg     <= sp_next;
            red_reg    <= red_next;
            rule_reg   <= rule_next;
            head_reg   <= head_next;
            ok_reg     <= ok_next;
            ov_reg     <= ov_next;
            kind_reg   <= kind_next;
            code_reg   <= code_next;
            top_o_reg  <= top_o_next;
            cause_reg  <= cause_next;
            last_reg   <= last_next;
        end
    end

    lrsp_ram #(.W(10), .DEPTH(AA_DEPTH), .AW(AA_W)) u_action (
        .clk (clk),
        .we  (act_we),
        .wa  (act_wa),
        .wd  (act_wd),
        .re  (act_re),
        .ra  (act_ra),
        .rd  (act_rd)
    );

    lrsp_ram #(.W(11), .DEPTH(RULES), .AW(RU_W)) u_rule (
        .clk (clk),
        .we  (rule_we),
        .wa  (rule_wa),
        .wd  (rule_wd),
        .re  (rule_re),
        .ra  (rule_ra),
        .rd  (rule_rd)
    );

    lrsp_ram #(.W(8), .DEPTH(SYMBOLS), .AW(SY_W)) u_map (
        .clk (clk),
        .we  (map_we),
        .wa  (map_wa),
        .wd  (token_id),
        .re  (map_re),
        .ra  (map_ra),
        .rd  (map_rd)
    );

    lrsp_ram #(.W(7), .DEPTH(STACK_DEPTH), .AW(SP_W)) u_stack (
        .clk (clk),
        .we  (stk_we),
        .wa  (stk_wa),
        .wd  (stk_wd),
        .re  (stk_re),
        .ra  (stk_ra),
        .rd  (stk_rd)
    );

    assign out_valid   = ov_reg;
    assign kind        = kind_reg;
    assign code        = code_reg;
    assign top_state   = top_o_reg;
    assign error_cause = cause_reg;
    assign last        = last_reg;

endmodule

FILE: rtl/lrsp_check.sv
module lrsp_check (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] kind,
    input logic [6:0] code,
    input logic [6:0] top_state,
    input logic [2:0] error_cause,
    input logic       last
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(code))
        else $error("result dropped while stalled");

    a_reduce: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == lrsp_pkg::R_REDUCE |-> !last && error_cause == lrsp_pkg::C_NONE)
        else $error("reduce result marked final or with a cause");

    a_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != lrsp_pkg::R_REDUCE |-> last)
        else $error("final result not marked last");

    a_reset_stack: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == lrsp_pkg::R_ACCEPT || kind == lrsp_pkg::R_ERROR)
        |-> code == 7'd0 && top_state == 7'd0)
        else $error("accept or error without stack reset");

    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((kind == lrsp_pkg::R_ERROR) == (error_cause != lrsp_pkg::C_NONE)))
        else $error("error cause does not match kind");

endmodule

bind lr_shift_reduce_parser lrsp_check u_lrsp_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .code        (code),
    .top_state   (top_state),
    .error_cause (error_cause),
    .last        (last)
);

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int LIMIT_CYCLES = 3000000;
    localparam int STACK_SIZE   = 64;
    localparam int REDUCE_CAP   = 63;

    // grammar symbols
    localparam int SYM_ID      = 1;
    localparam int SYM_PLUS    = 2;
    localparam int SYM_END     = 3;
    localparam int SYM_EXPR    = 4;
    localparam int SYM_TERM    = 5;
    localparam int SYM_LPAREN  = 6;
    localparam int SYM_RPAREN  = 7;
    localparam int SYM_LOOP    = 9;
    localparam int SYM_LOOP_HD = 10;
    localparam int SYM_DEEP    = 11;
    localparam int SYM_BLANK   = 12;
    localparam int SYM_GOTOACT = 13;
    localparam int SYM_BADKIND = 14;
    localparam int SYM_NOGO_HD = 15;
    localparam int SYM_NOGOTO  = 16;

    localparam int RULE_ADD    = 1;
    localparam int RULE_E_T    = 2;
    localparam int RULE_T_ID   = 3;
    localparam int RULE_PAREN  = 4;
    localparam int RULE_LOOP   = 5;
    localparam int RULE_DEEP   = 6;
    localparam int RULE_NOGOTO = 7;

    typedef struct packed {
        logic [1:0] kind;
        logic [6:0] code;
        logic [6:0] top;
        logic [2:0] cause;
        logic       last;
    } parse_result_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_index;
    logic [7:0] cfg_data;
    logic       in_valid;
    logic       in_stall;
    logic [1:0] func;
    logic [6:0] row;
    logic [6:0] column;
    logic [2:0] act_kind;
    logic [6:0] act_value;
    logic [3:0] body_length;
    logic [7:0] token_id;
    logic       end_of_input;
    logic       out_valid;
    logic       out_stall;
    logic [1:0] kind;
    logic [6:0] code;
    logic [6:0] top_state;
    logic [2:0] error_cause;
    logic       last;

    lr_shift_reduce_parser u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .row         (row),
        .column      (column),
        .act_kind    (act_kind),
        .act_value   (act_value),
        .body_length (body_length),
        .token_id    (token_id),
        .end_of_input(end_of_input),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .code        (code),
        .top_state   (top_state),
        .error_cause (error_cause),
        .last        (last)
    );

    // parser state mirror
    logic [2:0]    tbl_kind [128][128];
    logic [6:0]    tbl_val  [128][128];
    logic [3:0]    rule_len [128];
    logic [6:0]    rule_lhs [128];
    logic [7:0]    sym_map  [128];
    logic [6:0]    stk      [STACK_SIZE];
    int            sp;
    int            sym_count;
    int            end_sym;

    parse_result_t pending_results[$];
    int            seq_syms[$];
    int            mismatches;
    int            cycle_count;
    int            sent_count;
    bit            quiet;
    bit            hold_req;
    int            hold_left;
    int            stall_left;
    parse_result_t got;
    parse_result_t want;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_req = 1'b0;
            hold_left = 400;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (quiet)
            out_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 4);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{kind, code, top_state, error_cause, last};
            if (pending_results.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected result kind=%0d code=%0d top=%0d cause=%0d last=%0d",
                             kind, code, top_state, error_cause, last);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    if (mismatches < 10)
                        $display("mismatch: exp kind=%0d code=%0d top=%0d cause=%0d last=%0d %s",
                                 want.kind, want.code, want.top, want.cause, want.last,
                                 $sformatf("got kind=%0d code=%0d top=%0d cause=%0d last=%0d",
                                           kind, code, top_state, error_cause, last));
                    mismatches++;
                end
            end
        end
    end

    function automatic void add_result(logic [1:0] k, logic [6:0] c, logic [6:0] t,
                                       logic [2:0] cause, logic l);
        parse_result_t r;
        r = '{k, c, t, cause, l};
        pending_results.push_back(r);
    endfunction

    function automatic void clear_stack();
        for (int i = 0; i < STACK_SIZE; i++)
            stk[i] = '0;
        sp = 0;
    endfunction

    function automatic void abort_parse(logic [2:0] cause);
        clear_stack();
        add_result(lrsp_pkg::R_ERROR, '0, '0, cause, 1'b1);
    endfunction

    function automatic void parse_token(logic [7:0] tid, logic eoi);
        int         sym;
        bit         found;
        int         nred;
        logic [2:0] k;
        logic [6:0] v;
        int         len;
        logic [6:0] head;
        logic [6:0] below;
        nred = 0;
        sym = 0;
        found = 0;
        if (eoi)
            sym = end_sym;
        else
        begin
            for (int i = 0; i < sym_count && i < 128; i++)
                if (!found && sym_map[i] == tid)
                begin
                    sym = i;
                    found = 1;
                end
            if (!found)
            begin
                abort_parse(lrsp_pkg::C_UNKNOWN);
                return;
            end
        end
        while (1)
        begin
            k = tbl_kind[stk[sp]][sym];
            v = tbl_val[stk[sp]][sym];
            if (k == lrsp_pkg::K_SHIFT)
            begin
                if (sp + 1 >= STACK_SIZE)
                begin
                    abort_parse(lrsp_pkg::C_STACK);
                    return;
                end
                sp++;
                stk[sp] = v;
                add_result(lrsp_pkg::R_SHIFT, v, v, lrsp_pkg::C_NONE, 1'b1);
                return;
            end
            if (k == lrsp_pkg::K_ACCEPT)
            begin
                clear_stack();
                add_result(lrsp_pkg::R_ACCEPT, '0, '0, lrsp_pkg::C_NONE, 1'b1);
                return;
            end
            if (k != lrsp_pkg::K_REDUCE)
            begin
                abort_parse(lrsp_pkg::C_TABLE);
                return;
            end
            if (nred >= REDUCE_CAP)
            begin
                abort_parse(lrsp_pkg::C_LIMIT);
                return;
            end
            len = rule_len[v];
            head = rule_lhs[v];
            if (len > sp)
            begin
                abort_parse(lrsp_pkg::C_STACK);
                return;
            end
            sp -= len;
            below = stk[sp];
            if (tbl_kind[below][head] != lrsp_pkg::K_GOTO)
            begin
                abort_parse(lrsp_pkg::C_TABLE);
                return;
            end
            if (sp + 1 >= STACK_SIZE)
            begin
                abort_parse(lrsp_pkg::C_STACK);
                return;
            end
            sp++;
            stk[sp] = tbl_val[below][head];
            nred++;
            add_result(lrsp_pkg::R_REDUCE, v, stk[sp], lrsp_pkg::C_NONE, 1'b0);
        end
    endfunction

    function automatic void apply_item(logic [1:0] f, logic [6:0] r, logic [6:0] c,
                                       logic [2:0] ak, logic [6:0] av, logic [3:0] bl,
                                       logic [7:0] tid, logic eoi);
        case (f)
            lrsp_pkg::F_LOAD_ACTION:
            begin
                tbl_kind[r][c] = ak;
                tbl_val[r][c] = av;
            end
            lrsp_pkg::F_LOAD_RULE:
            begin
                rule_len[r] = (bl > 4'd8) ? 4'd8 : bl;
                rule_lhs[r] = av;
            end
            lrsp_pkg::F_LOAD_MAP:
                sym_map[r] = tid;
            default:
                parse_token(tid, eoi);
        endcase
    endfunction

    task automatic send_item(logic [1:0] f, logic [6:0] r, logic [6:0] c, logic [2:0] ak,
                             logic [6:0] av, logic [3:0] bl, logic [7:0] tid, logic eoi);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        row <= r;
        column <= c;
        act_kind <= ak;
        act_value <= av;
        body_length <= bl;
        token_id <= tid;
        end_of_input <= eoi;
        do
            @(posedge clk);
        while (in_stall);
        apply_item(f, r, c, ak, av, bl, tid, eoi);
        sent_count++;
    endtask

    task automatic stop_sending();
        in_valid <= 1'b0;
    endtask

    task automatic put_action(int s, int sym, logic [2:0] k, int v);
        send_item(lrsp_pkg::F_LOAD_ACTION, 7'(s), 7'(sym), k, 7'(v), 4'($urandom),
                  8'($urandom), 1'($urandom));
    endtask

    task automatic put_rule(int r, int len, int head);
        send_item(lrsp_pkg::F_LOAD_RULE, 7'(r), 7'($urandom), 3'($urandom), 7'(head),
                  4'(len), 8'($urandom), 1'($urandom));
    endtask

    task automatic send_token_id(logic [7:0] tid);
        send_item(lrsp_pkg::F_TOKEN, 7'($urandom), 7'($urandom), 3'($urandom),
                  7'($urandom), 4'($urandom), tid, 1'b0);
    endtask

    task automatic send_sym(int sym);
        if (sym == SYM_END)
            send_item(lrsp_pkg::F_TOKEN, 7'($urandom), 7'($urandom), 3'($urandom),
                      7'($urandom), 4'($urandom), 8'($urandom), 1'b1);
        else
            send_token_id(sym_map[sym]);
    endtask

    task automatic write_cfg(logic idx, logic [7:0] d);
        wait (pending_results.size() == 0);
        repeat (12) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == lrsp_pkg::CFG_SYMBOL_COUNT)
            sym_count = d;
        else
            end_sym = d[6:0];
    endtask

    task automatic load_grammar();
        for (int i = 0; i < 128; i++)
            send_item(lrsp_pkg::F_LOAD_MAP, 7'(i), 7'($urandom), 3'($urandom),
                      7'($urandom), 4'($urandom), 8'(2 * i + 1), 1'($urandom));
        put_rule(RULE_ADD, 3, SYM_EXPR);
        put_rule(RULE_E_T, 1, SYM_EXPR);
        put_rule(RULE_T_ID, 1, SYM_TERM);
        put_rule(RULE_PAREN, 3, SYM_TERM);
        put_rule(RULE_LOOP, 0, SYM_LOOP_HD);
        put_rule(RULE_DEEP, 15, SYM_EXPR);
        put_rule(RULE_NOGOTO, 0, SYM_NOGO_HD);
        put_action(0, SYM_ID, lrsp_pkg::K_SHIFT, 3);
        put_action(0, SYM_LPAREN, lrsp_pkg::K_SHIFT, 6);
        put_action(0, SYM_EXPR, lrsp_pkg::K_GOTO, 1);
        put_action(0, SYM_TERM, lrsp_pkg::K_GOTO, 2);
        put_action(0, SYM_LOOP, lrsp_pkg::K_REDUCE, RULE_LOOP);
        put_action(0, SYM_LOOP_HD, lrsp_pkg::K_GOTO, 0);
        put_action(0, SYM_DEEP, lrsp_pkg::K_REDUCE, RULE_DEEP);
        put_action(0, SYM_GOTOACT, lrsp_pkg::K_GOTO, 9);
        put_action(0, SYM_BADKIND, 3'd7, 5);
        put_action(0, SYM_NOGOTO, lrsp_pkg::K_REDUCE, RULE_NOGOTO);
        put_action(1, SYM_PLUS, lrsp_pkg::K_SHIFT, 4);
        put_action(1, SYM_END, lrsp_pkg::K_ACCEPT, 0);
        put_action(4, SYM_ID, lrsp_pkg::K_SHIFT, 3);
        put_action(4, SYM_LPAREN, lrsp_pkg::K_SHIFT, 6);
        put_action(4, SYM_TERM, lrsp_pkg::K_GOTO, 5);
        put_action(6, SYM_ID, lrsp_pkg::K_SHIFT, 3);
        put_action(6, SYM_LPAREN, lrsp_pkg::K_SHIFT, 6);
        put_action(6, SYM_EXPR, lrsp_pkg::K_GOTO, 7);
        put_action(6, SYM_TERM, lrsp_pkg::K_GOTO, 2);
        put_action(7, SYM_PLUS, lrsp_pkg::K_SHIFT, 4);
        put_action(7, SYM_RPAREN, lrsp_pkg::K_SHIFT, 8);
        for (int j = 0; j < 3; j++)
        begin
            int s;
            s = (j == 0) ? SYM_PLUS : (j == 1) ? SYM_END : SYM_RPAREN;
            put_action(2, s, lrsp_pkg::K_REDUCE, RULE_E_T);
            put_action(3, s, lrsp_pkg::K_REDUCE, RULE_T_ID);
            put_action(5, s, lrsp_pkg::K_REDUCE, RULE_ADD);
            put_action(8, s, lrsp_pkg::K_REDUCE, RULE_PAREN);
        end
        stop_sending();
    endtask

    task automatic test_directed_parse();
        send_sym(SYM_ID);
        send_sym(SYM_PLUS);
        send_sym(SYM_LPAREN);
        send_sym(SYM_ID);
        send_sym(SYM_PLUS);
        send_sym(SYM_ID);
        send_sym(SYM_RPAREN);
        send_sym(SYM_END);
        send_sym(SYM_LOOP);
        send_sym(SYM_DEEP);
        send_sym(SYM_BLANK);
        send_sym(SYM_GOTOACT);
        send_sym(SYM_BADKIND);
        send_sym(SYM_NOGOTO);
        send_token_id(8'd0);
        send_token_id(8'd255);
        send_sym(SYM_ID);
        send_sym(SYM_ID);
        send_sym(SYM_END);
        stop_sending();
    endtask

    task automatic test_config_extremes();
        write_cfg(lrsp_pkg::CFG_SYMBOL_COUNT, 8'd1);
        write_cfg(lrsp_pkg::CFG_END_SYMBOL, 8'd127);
        send_token_id(sym_map[0]);
        send_sym(SYM_ID);
        send_item(lrsp_pkg::F_TOKEN, '0, '0, '0, '0, '0, 8'd0, 1'b1);
        stop_sending();
        write_cfg(lrsp_pkg::CFG_SYMBOL_COUNT, 8'd128);
        write_cfg(lrsp_pkg::CFG_END_SYMBOL, 8'd0);
        send_item(lrsp_pkg::F_TOKEN, '0, '0, '0, '0, '0, 8'd0, 1'b1);
        stop_sending();
        write_cfg(lrsp_pkg::CFG_END_SYMBOL, 8'(SYM_END));
        send_sym(SYM_ID);
        send_sym(SYM_END);
        stop_sending();
    endtask

    task automatic test_stack_overflow();
        hold_req = 1'b1;
        repeat (66) send_sym(SYM_LPAREN);
        send_sym(SYM_END);
        stop_sending();
    endtask

    function automatic void gen_term(int depth);
        if (depth < 5 && $urandom_range(0, 2) == 0)
        begin
            seq_syms.push_back(SYM_LPAREN);
            gen_expr(depth + 1);
            seq_syms.push_back(SYM_RPAREN);
        end
        else
            seq_syms.push_back(SYM_ID);
    endfunction

    function automatic void gen_expr(int depth);
        int n;
        n = $urandom_range(0, 2);
        gen_term(depth);
        repeat (n)
        begin
            seq_syms.push_back(SYM_PLUS);
            gen_term(depth);
        end
    endfunction

    task automatic send_noise();
        case ($urandom_range(0, 3))
            0: put_action($urandom_range(64, 127), $urandom_range(0, 127), 3'($urandom),
                          $urandom_range(0, 127));
            1: put_rule($urandom_range(64, 127), $urandom_range(0, 15), $urandom);
            2: send_item(lrsp_pkg::F_LOAD_MAP, 7'($urandom_range(32, 127)), 7'($urandom),
                         3'($urandom), 7'($urandom), 4'($urandom), 8'($urandom),
                         1'($urandom));
            default: send_item(lrsp_pkg::F_TOKEN, 7'($urandom), 7'($urandom), 3'($urandom),
                               7'($urandom), 4'($urandom), 8'($urandom),
                               $urandom_range(0, 7) == 0);
        endcase
    endtask

    task automatic test_random_parse();
        int target;
        int cut;
        target = sent_count + 190;
        while (sent_count < target)
        begin
            if (sent_count > target - 40)
                quiet = 1'b1;
            if ($urandom_range(0, 7) == 0)
            begin
                stop_sending();
                write_cfg(lrsp_pkg::CFG_SYMBOL_COUNT, 8'(($urandom_range(0, 2) == 0) ?
                          $urandom_range(1, 128) : $urandom_range(17, 128)));
                write_cfg(lrsp_pkg::CFG_END_SYMBOL, 8'(($urandom_range(0, 3) == 0) ?
                          $urandom_range(0, 127) : SYM_END));
            end
            seq_syms.delete();
            gen_expr(0);
            seq_syms.push_back(SYM_END);
            if ($urandom_range(0, 5) == 0)
            begin
                cut = $urandom_range(0, seq_syms.size() - 1);
                if ($urandom_range(0, 1))
                    seq_syms.delete(cut);
                else
                    seq_syms.insert(cut, $urandom_range(1, 16));
            end
            foreach (seq_syms[i])
            begin
                if ($urandom_range(0, 19) == 0)
                    send_noise();
                send_sym(seq_syms[i]);
            end
        end
        stop_sending();
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = lrsp_pkg::CFG_SYMBOL_COUNT;
        cfg_data = '0;
        in_valid = 1'b0;
        func = lrsp_pkg::F_LOAD_ACTION;
        row = '0;
        column = '0;
        act_kind = lrsp_pkg::K_ERROR;
        act_value = '0;
        body_length = '0;
        token_id = '0;
        end_of_input = 1'b0;
        out_stall = 1'b0;
        mismatches = 0;
        cycle_count = 0;
        sent_count = 0;
        quiet = 1'b0;
        hold_req = 1'b0;
        hold_left = 0;
        stall_left = 0;
        sym_count = 128;
        end_sym = 0;
        for (int i = 0; i < 128; i++)
        begin
            rule_len[i] = '0;
            rule_lhs[i] = '0;
            sym_map[i] = '0;
            for (int j = 0; j < 128; j++)
            begin
                tbl_kind[i][j] = lrsp_pkg::K_ERROR;
                tbl_val[i][j] = '0;
            end
        end
        clear_stack();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        write_cfg(lrsp_pkg::CFG_END_SYMBOL, 8'(SYM_END));
        load_grammar();
        test_directed_parse();
        test_config_extremes();
        test_stack_overflow();
        test_random_parse();
        wait (pending_results.size() == 0);
        repeat (50) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: files.f
rtl/lrsp_pkg.sv
rtl/lrsp_ram.sv
rtl/lr_shift_reduce_parser.sv
rtl/lrsp_check.sv
tb/sv/tb.sv
